// ===== hw/rtl/bqs_pkg.sv =====
// ---------------------------------------------------------------------------
// bqs_pkg
// Shared widths, register indexes, ranking codes and types of the best quote
// selector.
// ---------------------------------------------------------------------------
`default_nettype none

package bqs_pkg;

    localparam int VAL_W           = 64;
    localparam int HALF_W          = VAL_W / 2;
    localparam int PROD_W          = 2 * VAL_W;
    localparam int RATIO_W         = 17;
    localparam int MODE_W          = 2;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int R_W             = (RATIO_FRAC_BITS < RATIO_W) ? RATIO_FRAC_BITS + 1 : RATIO_W;
    localparam int TAG_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_RATIO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_MODE    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PRICE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COST  = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0]   request_size;
        logic [RATIO_W-1:0] fill_ratio;
        logic [MODE_W-1:0]  rank_mode;
    } cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0] fill;
        logic [VAL_W-1:0] cost;
        logic [VAL_W-1:0] cost_mag;
        logic             cost_neg;
        logic             fill_bad;
        logic             pass;
        logic             last;
    } quote_t;

endpackage

`default_nettype wire

// ===== hw/rtl/best_quote_selector_core.sv =====
// ---------------------------------------------------------------------------
// best_quote_selector_core
// Picks the best quote of each run and returns it when the run ends.
// ---------------------------------------------------------------------------
// Quotes enter on the s_ stream at up to one transfer per cycle, while
// s_tready is high, into a two-stage front that applies the minimum fill
// filter, then wait in a four-entry queue. The ranking sequencer settles a
// quote in its evaluate state alone, or steps through evaluate, sum and
// decide when a quote that passes the filter needs the exact 128-bit cross
// products against a kept best (price mode with both fills positive, or fill
// mode on equal positive fills); that compare-and-update loop on the kept
// best sets the sustained rate. The winner of a run appears on the m_ stream
// once its last quote is ranked, held in an output register until taken.
`default_nettype none

module best_quote_selector_core #(
    parameter int TAG_BITS = bqs_pkg::TAG_BITS_DEF,
    parameter int TDATA_W  = ((2 * bqs_pkg::VAL_W + TAG_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bqs_pkg::CFG_IDX_W-1:0] cfg_wr_idx,
    input  logic [bqs_pkg::VAL_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [TDATA_W-1:0]            s_tdata,  // quote_fill, quote_cost, quote_tag
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata,  // best_fill, best_cost, best_tag
    output logic                          m_tuser   // found
);

    localparam int VW = bqs_pkg::VAL_W;
    localparam int QW = $bits(bqs_pkg::quote_t) + TAG_BITS;

    bqs_pkg::cfg_t       cfg_reg;
    logic                q_push;
    bqs_pkg::quote_t     q_in_quote;
    logic [TAG_BITS-1:0] q_in_tag;
    logic                q_ready;
    logic                q_pop;
    logic                q_valid;
    logic [QW-1:0]       q_out_data;
    logic                out_found;
    logic [VW-1:0]       out_fill;
    logic [VW-1:0]       out_cost;
    logic [TAG_BITS-1:0] out_tag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                bqs_pkg::CFG_REQUEST_SIZE: cfg_reg.request_size <= cfg_wr_data;
                bqs_pkg::CFG_FILL_RATIO:   cfg_reg.fill_ratio   <= cfg_wr_data[bqs_pkg::RATIO_W-1:0];
                bqs_pkg::CFG_RANK_MODE:    cfg_reg.rank_mode    <= cfg_wr_data[bqs_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    bqs_front #(
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_fill  (s_tdata[VW-1:0]),
        .in_cost  (s_tdata[2*VW-1:VW]),
        .in_tag   (s_tdata[2*VW +: TAG_BITS]),
        .in_last  (s_tlast),
        .q_push   (q_push),
        .q_quote  (q_in_quote),
        .q_tag    (q_in_tag),
        .q_ready  (q_ready)
    );

    bqs_queue #(
        .WIDTH (QW),
        .DEPTH (bqs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  ({q_in_tag, q_in_quote}),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_out_data),
        .pop_valid  (q_valid)
    );

    bqs_back #(
        .TAG_BITS (TAG_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rank_mode (cfg_reg.rank_mode),
        .q_valid   (q_valid),
        .q_quote   (q_out_data[$bits(bqs_pkg::quote_t)-1:0]),
        .q_tag     (q_out_data[QW-1:$bits(bqs_pkg::quote_t)]),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (out_found),
        .out_fill  (out_fill),
        .out_cost  (out_cost),
        .out_tag   (out_tag)
    );

    assign m_tdata = TDATA_W'({out_tag, out_cost, out_fill});
    assign m_tuser = out_found;

endmodule

`default_nettype wire

// ===== hw/rtl/bqs_front.sv =====
// ---------------------------------------------------------------------------
// bqs_front
// Input stages: take quotes, classify fill and cost, apply the minimum fill
// filter and push the classified quote into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module bqs_front #(
    parameter int TAG_BITS = bqs_pkg::TAG_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bqs_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bqs_pkg::VAL_W-1:0] in_fill,
    input  logic [bqs_pkg::VAL_W-1:0] in_cost,
    input  logic [TAG_BITS-1:0]       in_tag,
    input  logic                      in_last,
    output logic                      q_push,
    output bqs_pkg::quote_t           q_quote,
    output logic [TAG_BITS-1:0]       q_tag,
    input  logic                      q_ready
);

    localparam int VW   = bqs_pkg::VAL_W;
    localparam int F    = bqs_pkg::RATIO_FRAC_BITS;
    localparam int RW   = bqs_pkg::R_W;
    localparam int HI_W = VW - F;
    localparam int HP_W = (HI_W + RW + 1 > VW) ? HI_W + RW + 1 : VW;
    localparam int LO_W = F + RW + 1;
    localparam logic [VW-1:0] RATIO_ONE = {{(VW-1){1'b0}}, 1'b1} << F;

    logic [RW-1:0]          ratio_clamp;
    logic signed [HI_W-1:0] rs_hi;
    logic [F-1:0]           rs_lo;
    logic signed [HP_W-1:0] hi_prod;
    logic [LO_W-1:0]        lo_prod;
    logic [VW-1:0]          min_fill_next;
    logic [VW-1:0]          min_fill_reg;

    logic                   s1_valid_reg;
    logic [VW-1:0]          s1_fill_reg;
    logic [VW-1:0]          s1_cost_reg;
    logic [TAG_BITS-1:0]    s1_tag_reg;
    logic                   s1_last_reg;
    logic                   s2_valid_reg;
    bqs_pkg::quote_t        s2_quote_reg;
    logic [TAG_BITS-1:0]    s2_tag_reg;
    logic                   en1;
    logic                   en2;

    always_comb begin
        if ({{(VW-bqs_pkg::RATIO_W){1'b0}}, cfg.fill_ratio} > RATIO_ONE) begin
            ratio_clamp = RW'(RATIO_ONE);
        end else begin
            ratio_clamp = RW'(cfg.fill_ratio);
        end
    end

    assign rs_hi   = $signed(cfg.request_size[VW-1:F]);
    assign rs_lo   = cfg.request_size[F-1:0];
    assign hi_prod = rs_hi * $signed({1'b0, ratio_clamp});
    assign lo_prod = LO_W'(rs_lo) * LO_W'(ratio_clamp) + LO_W'(RATIO_ONE - 1'b1);
    assign min_fill_next = hi_prod[VW-1:0] + VW'(lo_prod[LO_W-1:F]);

    always_ff @(posedge aclk) begin
        min_fill_reg <= min_fill_next;
    end

    assign en2      = !s2_valid_reg || q_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                s1_valid_reg <= in_valid;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_fill_reg <= in_fill;
            s1_cost_reg <= in_cost;
            s1_tag_reg  <= in_tag;
            s1_last_reg <= in_last;
        end
        if (en2) begin
            s2_quote_reg.fill     <= s1_fill_reg;
            s2_quote_reg.cost     <= s1_cost_reg;
            s2_quote_reg.cost_mag <= s1_cost_reg[VW-1] ? (VW'(0) - s1_cost_reg) : s1_cost_reg;
            s2_quote_reg.cost_neg <= s1_cost_reg[VW-1];
            s2_quote_reg.fill_bad <= s1_fill_reg[VW-1] || (s1_fill_reg == '0);
            s2_quote_reg.pass     <= 1'b0;
            s2_quote_reg.last     <= s1_last_reg;
            s2_tag_reg            <= s1_tag_reg;
        end
    end

    always_comb begin
        q_quote      = s2_quote_reg;
        q_quote.pass = !($signed(s2_quote_reg.fill) < $signed(min_fill_reg));
    end

    assign q_push = s2_valid_reg && q_ready;
    assign q_tag  = s2_tag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bqs_queue.sv =====
// ---------------------------------------------------------------------------
// bqs_queue
// Short first-word-fall-through queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module bqs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bqs_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bqs_back.sv =====
// ---------------------------------------------------------------------------
// bqs_back
// Ranking sequencer: compare each queued quote against the kept best, by
// exact cross-multiplication where the rule needs it, and deliver the winner
// at the end of a run through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bqs_back #(
    parameter int TAG_BITS = bqs_pkg::TAG_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [bqs_pkg::MODE_W-1:0] rank_mode,
    input  logic                       q_valid,
    input  bqs_pkg::quote_t            q_quote,
    input  logic [TAG_BITS-1:0]        q_tag,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_found,
    output logic [bqs_pkg::VAL_W-1:0]  out_fill,
    output logic [bqs_pkg::VAL_W-1:0]  out_cost,
    output logic [TAG_BITS-1:0]        out_tag
);

    localparam int VW = bqs_pkg::VAL_W;
    localparam int HW = bqs_pkg::HALF_W;
    localparam int PW = bqs_pkg::PROD_W;

    localparam logic [1:0] PH_EVAL   = 2'd0;
    localparam logic [1:0] PH_SUM    = 2'd1;
    localparam logic [1:0] PH_DECIDE = 2'd2;

    function automatic logic [PW-1:0] join_pp(input logic [VW-1:0] p00, input logic [VW-1:0] p01,
                                              input logic [VW-1:0] p10, input logic [VW-1:0] p11);
        return {{VW{1'b0}}, p00} + {{HW{1'b0}}, p01, {HW{1'b0}}}
             + {{HW{1'b0}}, p10, {HW{1'b0}}} + {p11, {VW{1'b0}}};
    endfunction

    logic                w_valid_reg;
    logic [1:0]          phase_reg;
    bqs_pkg::quote_t     w_reg;
    logic [TAG_BITS-1:0] w_tag_reg;

    logic                have_best_reg;
    logic [VW-1:0]       kept_fill_reg;
    logic [VW-1:0]       kept_cost_reg;
    logic [VW-1:0]       kept_mag_reg;
    logic                kept_neg_reg;
    logic                kept_bad_reg;
    logic [TAG_BITS-1:0] kept_tag_reg;

    logic [VW-1:0]       pp_a_reg [4];
    logic [VW-1:0]       pp_b_reg [4];
    logic [PW-1:0]       prod_a_reg;
    logic [PW-1:0]       prod_b_reg;

    logic                out_valid_reg;
    logic                out_found_reg;
    logic [VW-1:0]       out_fill_reg;
    logic [VW-1:0]       out_cost_reg;
    logic [TAG_BITS-1:0] out_tag_reg;

    logic                fill_eq;
    logic                kept_below;
    logic                need_mul;
    logic                price_lt;
    logic                price_eq;
    logic                better;
    logic                done_step;
    logic                out_free;
    logic                finish;
    logic                found_after;

    assign fill_eq    = (w_reg.fill == kept_fill_reg);
    assign kept_below = $signed(kept_fill_reg) < $signed(w_reg.fill);
    assign need_mul   = w_reg.pass && have_best_reg && !w_reg.fill_bad && !kept_bad_reg
                     && ((rank_mode == bqs_pkg::MODE_PRICE)
                         || ((rank_mode == bqs_pkg::MODE_FILL) && fill_eq));

    always_comb begin
        if (w_reg.fill_bad || kept_bad_reg) begin
            price_lt = !w_reg.fill_bad && kept_bad_reg;
            price_eq = w_reg.fill_bad && kept_bad_reg;
        end else if (w_reg.cost_neg != kept_neg_reg) begin
            price_lt = w_reg.cost_neg;
            price_eq = 1'b0;
        end else begin
            price_eq = (prod_a_reg == prod_b_reg);
            price_lt = w_reg.cost_neg ? (prod_a_reg > prod_b_reg) : (prod_a_reg < prod_b_reg);
        end
    end

    always_comb begin
        better = 1'b0;
        if (!have_best_reg) begin
            better = 1'b1;
        end else begin
            case (rank_mode)
                bqs_pkg::MODE_PRICE: better = price_lt || (price_eq && kept_below);
                bqs_pkg::MODE_FILL:  better = kept_below || (fill_eq && price_lt);
                bqs_pkg::MODE_COST:  better = $signed(w_reg.cost) < $signed(kept_cost_reg);
                default:             better = 1'b0;
            endcase
        end
        better = better && w_reg.pass;
    end

    always_comb begin
        case (phase_reg)
            PH_EVAL:   done_step = w_valid_reg && !need_mul;
            PH_DECIDE: done_step = w_valid_reg;
            default:   done_step = 1'b0;
        endcase
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign finish      = done_step && (!w_reg.last || out_free);
    assign q_pop       = q_valid && (!w_valid_reg || finish);
    assign found_after = have_best_reg || better;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg   <= 1'b0;
            phase_reg     <= PH_EVAL;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                w_valid_reg <= 1'b1;
                phase_reg   <= PH_EVAL;
            end else if (finish) begin
                w_valid_reg <= 1'b0;
                phase_reg   <= PH_EVAL;
            end else if (w_valid_reg) begin
                case (phase_reg)
                    PH_EVAL:   phase_reg <= need_mul ? PH_SUM : PH_EVAL;
                    PH_SUM:    phase_reg <= PH_DECIDE;
                    PH_DECIDE: phase_reg <= PH_DECIDE;
                    default:   phase_reg <= PH_EVAL;
                endcase
            end
            if (finish) begin
                have_best_reg <= w_reg.last ? 1'b0 : found_after;
            end
            if (finish && w_reg.last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            w_reg     <= q_quote;
            w_tag_reg <= q_tag;
        end
        if (finish && better) begin
            kept_fill_reg <= w_reg.fill;
            kept_cost_reg <= w_reg.cost;
            kept_mag_reg  <= w_reg.cost_mag;
            kept_neg_reg  <= w_reg.cost_neg;
            kept_bad_reg  <= w_reg.fill_bad;
            kept_tag_reg  <= w_tag_reg;
        end
        if (finish && w_reg.last) begin
            out_found_reg <= found_after;
            if (better) begin
                out_fill_reg <= w_reg.fill;
                out_cost_reg <= w_reg.cost;
                out_tag_reg  <= w_tag_reg;
            end else if (have_best_reg) begin
                out_fill_reg <= kept_fill_reg;
                out_cost_reg <= kept_cost_reg;
                out_tag_reg  <= kept_tag_reg;
            end else begin
                out_fill_reg <= '0;
                out_cost_reg <= '0;
                out_tag_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == PH_EVAL) begin
            pp_a_reg[0] <= w_reg.cost_mag[HW-1:0]  * kept_fill_reg[HW-1:0];
            pp_a_reg[1] <= w_reg.cost_mag[HW-1:0]  * kept_fill_reg[VW-1:HW];
            pp_a_reg[2] <= w_reg.cost_mag[VW-1:HW] * kept_fill_reg[HW-1:0];
            pp_a_reg[3] <= w_reg.cost_mag[VW-1:HW] * kept_fill_reg[VW-1:HW];
            pp_b_reg[0] <= kept_mag_reg[HW-1:0]    * w_reg.fill[HW-1:0];
            pp_b_reg[1] <= kept_mag_reg[HW-1:0]    * w_reg.fill[VW-1:HW];
            pp_b_reg[2] <= kept_mag_reg[VW-1:HW]   * w_reg.fill[HW-1:0];
            pp_b_reg[3] <= kept_mag_reg[VW-1:HW]   * w_reg.fill[VW-1:HW];
        end
        if (phase_reg == PH_SUM) begin
            prod_a_reg <= join_pp(pp_a_reg[0], pp_a_reg[1], pp_a_reg[2], pp_a_reg[3]);
            prod_b_reg <= join_pp(pp_b_reg[0], pp_b_reg[1], pp_b_reg[2], pp_b_reg[3]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_fill  = out_fill_reg;
    assign out_cost  = out_cost_reg;
    assign out_tag   = out_tag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bqs_checker.sv =====
// ---------------------------------------------------------------------------
// bqs_checker
// Port-level checks on the best quote selector, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bqs_checker #(
    parameter int TAG_BITS = bqs_pkg::TAG_BITS_DEF,
    parameter int TDATA_W  = ((2 * bqs_pkg::VAL_W + TAG_BITS + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("result without winner carries non-zero fields");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind best_quote_selector_core bqs_checker #(
    .TAG_BITS (TAG_BITS),
    .TDATA_W  (TDATA_W)
) u_bqs_checker (.*);

`default_nettype wire

// ===== bench/tb_best_quote_selector_core.sv =====
// ---------------------------------------------------------------------------
// tb_best_quote_selector_core
// Self-checking bench for the best quote selector. Quotes are streamed in as
// runs closed by tlast, and a bit-exact predictor picks each run's winner
// under the programmed fill floor and rank mode. Each result transfer is
// compared field by field with the oldest predicted winner. Directed runs
// cover ranking ties, field extremes and floor corner cases. Random runs
// follow under changing settings, sender idling, receiver stalls and a long
// result hold-off.
// ---------------------------------------------------------------------------
module tb_best_quote_selector_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VAL_W     = bqs_pkg::VAL_W;
    localparam int MODE_W    = bqs_pkg::MODE_W;
    localparam int RATIO_W   = bqs_pkg::RATIO_W;
    localparam int CFG_IDX_W = bqs_pkg::CFG_IDX_W;
    localparam int FRAC_BITS = bqs_pkg::RATIO_FRAC_BITS;

    localparam int DATA_W      = ((2 * VAL_W + 16 + 7) / 8) * 8;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 400000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_NONE = 2'd3;

    localparam logic [RATIO_W-1:0]   RATIO_ONE = RATIO_W'(1) << FRAC_BITS;
    localparam logic signed [63:0]   VMAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]   VMIN      = 64'sh8000_0000_0000_0000;

    typedef struct {
        bit                 found;
        logic signed [63:0] fill;
        logic signed [63:0] cost;
        logic [15:0]        tag;
    } pick_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_idx;
    logic [VAL_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic                 m_tuser;

    // predictor copy of the registers and the kept best
    logic signed [63:0]   cfg_size;
    logic [RATIO_W-1:0]   cfg_ratio;
    logic [MODE_W-1:0]    cfg_mode;
    bit                   has_winner;
    logic signed [63:0]   win_fill;
    logic signed [63:0]   win_cost;
    logic [15:0]          win_tag;

    pick_t                winner_q[$];
    int                   errors;
    int                   quotes_sent;
    int                   results_seen;
    int                   cycles;
    int                   send_idle;
    int                   stall_pct;
    logic                 hold_on;

    best_quote_selector_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_idx (cfg_wr_idx),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_best_quote_selector_core failed");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // ---------------------------------------------------------------- predictor
    function automatic logic signed [63:0] fill_floor();
        logic signed [127:0] prod;
        logic [RATIO_W-1:0]  r;
        r    = (cfg_ratio > RATIO_ONE) ? RATIO_ONE : cfg_ratio;
        prod = cfg_size * $signed({1'b0, r});
        prod = (prod + ((128'sd1 <<< FRAC_BITS) - 128'sd1)) >>> FRAC_BITS;
        return prod[63:0];
    endfunction

    // <0 when quote a is cheaper per unit filled than quote b
    function automatic int price_order(input logic signed [63:0] fa, input logic signed [63:0] ca,
                                       input logic signed [63:0] fb, input logic signed [63:0] cb);
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        bit                  a_bad;
        bit                  b_bad;
        a_bad = (fa <= 0);
        b_bad = (fb <= 0);
        if (a_bad || b_bad)
            return (a_bad && b_bad) ? 0 : (a_bad ? 1 : -1);
        lhs = ca * fb;
        rhs = cb * fa;
        return (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
    endfunction

    function automatic void rank_quote(input logic signed [63:0] fill,
                                       input logic signed [63:0] cost,
                                       input logic [15:0] tag, input bit last);
        bit    better;
        int    c;
        pick_t w;
        better = 1'b0;
        if (fill >= fill_floor()) begin
            if (!has_winner) begin
                better = 1'b1;
            end else begin
                case (cfg_mode)
                    bqs_pkg::MODE_PRICE: begin
                        c = price_order(fill, cost, win_fill, win_cost);
                        better = (c < 0) || (c == 0 && win_fill < fill);
                    end
                    bqs_pkg::MODE_FILL: begin
                        better = (win_fill < fill) ||
                                 (fill == win_fill &&
                                  price_order(fill, cost, win_fill, win_cost) < 0);
                    end
                    bqs_pkg::MODE_COST: begin
                        better = cost < win_cost;
                    end
                    default: begin
                        better = 1'b0;
                    end
                endcase
            end
            if (better) begin
                has_winner = 1'b1;
                win_fill   = fill;
                win_cost   = cost;
                win_tag    = tag;
            end
        end
        if (last) begin
            w.found = has_winner;
            w.fill  = has_winner ? win_fill : '0;
            w.cost  = has_winner ? win_cost : '0;
            w.tag   = has_winner ? win_tag : '0;
            winner_q.insert(winner_q.size(), w);
            has_winner = 1'b0;
            win_fill   = '0;
            win_cost   = '0;
            win_tag    = '0;
        end
    endfunction

    // ---------------------------------------------------------------- drivers
    function automatic int draw_gap();
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < send_idle)
            n++;
        return n;
    endfunction

    task automatic offer_quote(input logic signed [63:0] fill, input logic signed [63:0] cost,
                               input logic [15:0] tag, input bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, cost, fill};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        quotes_sent++;
        rank_quote(fill, cost, tag, last);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            bqs_pkg::CFG_REQUEST_SIZE: cfg_size  = data;
            bqs_pkg::CFG_FILL_RATIO:   cfg_ratio = data[RATIO_W-1:0];
            bqs_pkg::CFG_RANK_MODE:    cfg_mode  = data[MODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [63:0] size, input logic [63:0] ratio_word,
                                  input logic [63:0] mode_word);
        write_reg(bqs_pkg::CFG_REQUEST_SIZE, size);
        write_reg(bqs_pkg::CFG_FILL_RATIO, ratio_word);
        write_reg(bqs_pkg::CFG_RANK_MODE, mode_word);
        cfg_wr_en <= 1'b0;
    endtask

    // stop offering, let every winner out, then let the block settle
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (winner_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_on)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        pick_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (winner_q.size() == 0) begin
                report("result transfer with no run pending");
            end else begin
                w = winner_q.pop_front();
                results_seen++;
                if (m_tuser !== w.found)
                    report($sformatf("found got %b want %b", m_tuser, w.found));
                if (m_tdata[63:0] !== w.fill)
                    report($sformatf("best_fill got %h want %h", m_tdata[63:0], w.fill));
                if (m_tdata[127:64] !== w.cost)
                    report($sformatf("best_cost got %h want %h", m_tdata[127:64], w.cost));
                if (m_tdata[143:128] !== w.tag)
                    report($sformatf("best_tag got %h want %h", m_tdata[143:128], w.tag));
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_price_ranking();
        apply_settings(64'd0, 64'd0, 64'(bqs_pkg::MODE_PRICE));
        // equal unit prices: larger fill wins; zero fill ranks last
        offer_quote(0, 5, 16'h0001, 1'b0);
        offer_quote(10, 30, 16'h0002, 1'b0);
        offer_quote(20, 60, 16'h0003, 1'b0);
        offer_quote(5, 15, 16'h0004, 1'b0);
        offer_quote(7, 100, 16'h0005, 1'b1);
        offer_quote(VMAX, VMIN, 16'hFFFF, 1'b1);
        // negative fill dropped; full tie keeps the earlier quote
        offer_quote(-1, 0, 16'h0007, 1'b0);
        offer_quote(4, 8, 16'h00AA, 1'b0);
        offer_quote(4, 8, 16'h0055, 1'b1);
        // two non-positive fills tie
        offer_quote(0, 9, 16'h0011, 1'b0);
        offer_quote(0, -9, 16'h0022, 1'b1);
        wait_results();
    endtask

    task automatic test_fill_floor();
        // ratio above one clamps to one
        apply_settings(64'd1000, 64'h1_FFFF, 64'(bqs_pkg::MODE_PRICE));
        offer_quote(999, 1, 16'h0001, 1'b0);
        offer_quote(1000, 50, 16'h0002, 1'b1);
        wait_results();
        // zero ratio: floor is zero whatever the size
        apply_settings(VMAX, 64'd0, 64'(bqs_pkg::MODE_FILL));
        offer_quote(0, VMIN, 16'h0003, 1'b1);
        wait_results();
        // negative size: floor ceil(-500.5) = -500
        apply_settings(-64'sd1001, 64'd32768, 64'(bqs_pkg::MODE_COST));
        offer_quote(-500, 7, 16'h0004, 1'b0);
        offer_quote(-501, -100, 16'h0005, 1'b1);
        wait_results();
        apply_settings(VMIN, 64'(RATIO_ONE), 64'(bqs_pkg::MODE_PRICE));
        offer_quote(VMIN, VMAX, 16'h8000, 1'b1);
        wait_results();
        // nothing passes
        apply_settings(64'd100, 64'(RATIO_ONE), 64'(bqs_pkg::MODE_PRICE));
        offer_quote(99, 3, 16'h0006, 1'b1);
        wait_results();
    endtask

    task automatic test_rank_modes();
        apply_settings(64'd0, 64'd0, 64'(bqs_pkg::MODE_FILL));
        offer_quote(10, 50, 16'h0001, 1'b0);
        offer_quote(10, 40, 16'h0002, 1'b0);
        offer_quote(9, 1, 16'h0003, 1'b0);
        offer_quote(10, 40, 16'h0004, 1'b1);
        wait_results();
        apply_settings(64'd0, 64'd0, 64'(bqs_pkg::MODE_COST));
        offer_quote(5, 100, 16'h0001, 1'b0);
        offer_quote(5, -3, 16'h0002, 1'b0);
        offer_quote(1, -3, 16'h0003, 1'b1);
        wait_results();
        // spare index must leave the registers alone; mode three keeps the first
        write_reg(CFG_SPARE, {$urandom, $urandom});
        apply_settings(64'd0, 64'd0, 64'(MODE_NONE));
        offer_quote(3, 1, 16'h0001, 1'b0);
        offer_quote(4, 0, 16'h0002, 1'b1);
        wait_results();
    endtask

    function automatic logic signed [63:0] pick_value(input logic signed [63:0] centre);
        case ($urandom_range(9))
            0:       return VMAX;
            1:       return VMIN;
            2, 3:    return $signed(64'($urandom_range(70))) - 64'sd10;
            4, 5, 6: return centre + $signed(64'($urandom_range(6))) - 64'sd3;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic pick_settings(input logic [MODE_W-1:0] mode);
        logic signed [63:0] size;
        logic [63:0]        rw;
        logic [63:0]        mw;
        rw = {$urandom, $urandom};
        mw = {$urandom, $urandom};
        mw[MODE_W-1:0] = mode;
        case ($urandom_range(5))
            0: begin size = 0; rw[RATIO_W-1:0] = 0; end
            1: begin
                size = 64'($urandom_range(60));
                rw[RATIO_W-1:0] = RATIO_W'($urandom_range(RATIO_ONE));
            end
            2: begin
                size = -$signed(64'($urandom_range(60)));
                rw[RATIO_W-1:0] = RATIO_W'($urandom_range(RATIO_ONE));
            end
            3: begin size = {$urandom, $urandom}; rw[RATIO_W-1:0] = 0; end
            4: begin size = {$urandom, $urandom}; end
            default: begin
                size = $urandom_range(1) ? VMAX : VMIN;
                rw[RATIO_W-1:0] = RATIO_ONE;
            end
        endcase
        apply_settings(size, rw, mw);
    endtask

    task automatic test_random_runs(input int quotes, input int idle, input int stall,
                                    input logic [MODE_W-1:0] mode);
        int n;
        int len;
        pick_settings(mode);
        send_idle = idle;
        stall_pct = stall;
        n = 0;
        while (n < quotes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                offer_quote(pick_value(fill_floor()), pick_value(0),
                            16'($urandom_range(16'hFFFF)), i == len - 1);
                n++;
            end
        end
        wait_results();
    endtask

    task automatic test_output_hold();
        pick_settings(MODE_W'($urandom_range(2)));
        send_idle = 0;
        stall_pct = 0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_on <= 1'b0;
            end
            for (int i = 0; i < 24; i++)
                offer_quote(pick_value(fill_floor()), pick_value(0),
                            16'($urandom_range(16'hFFFF)), i[0]);
        join
        wait_results();
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_idx  <= '0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        m_tready    <= 1'b0;
        hold_on     <= 1'b0;
        send_idle   = 0;
        stall_pct   = 0;
        cfg_size    = '0;
        cfg_ratio   = '0;
        cfg_mode    = bqs_pkg::MODE_PRICE;
        has_winner  = 1'b0;
        win_fill    = '0;
        win_cost    = '0;
        win_tag     = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_price_ranking();
        test_fill_floor();
        test_rank_modes();
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: test_random_runs(42, 0, 0, MODE_W'(p / 2));
                1: test_random_runs(42, 80, 0, MODE_W'(p / 2));
                2: test_random_runs(42, 0, 80, MODE_W'(p / 2));
                default: test_random_runs(42, 16, 16, MODE_W'(p / 2));
            endcase
        end
        test_output_hold();

        if (winner_q.size() != 0)
            report($sformatf("%0d winners never delivered", winner_q.size()));
        $display("run covered %0d quotes and %0d winners across all rank modes,", quotes_sent,
                 results_seen);
        $display("clamped, zero and negative fill floors, idle/stall mixes and a long hold-off");
        if (errors == 0)
            $display("tb_best_quote_selector_core passed");
        else
            $display("tb_best_quote_selector_core failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bqs_pkg.sv
hw/rtl/bqs_front.sv
hw/rtl/bqs_queue.sv
hw/rtl/bqs_back.sv
hw/rtl/best_quote_selector_core.sv
hw/rtl/bqs_checker.sv
bench/tb_best_quote_selector_core.sv
